[src/yrlb_pkg.sv]
// ----------------------------------------------------------------------------
// yrlb_pkg
// Shared constants for the YPbPr to RGB converter with low-light luma blend:
// field widths, BT.709 factors in Q16, mask constants and register indexes.
// ----------------------------------------------------------------------------
package yrlb_pkg;

    localparam int SAMPLE_FRAC_BITS_DEF = 6;

    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int IN_DATA_W  = 3 * SAMPLE_W + 3 * BYTE_W;
    localparam int OUT_DATA_W = 3 * BYTE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_LOWLIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIAN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST   = 2'd3;

    localparam int CONV_W  = 34;
    localparam int NUM_W   = 38;
    localparam int T_W     = 20;
    localparam int T_CALC_W = 22;
    localparam int QUOT_W  = 17;
    localparam int MASK_W  = 17;
    localparam int OPART_W = BYTE_W + MASK_W;

    localparam logic signed [CONV_W-1:0] CR_Q16 = 34'sd103206;
    localparam logic signed [CONV_W-1:0] CB_Q16 = 34'sd121609;
    localparam logic signed [CONV_W-1:0] GR_Q16 = 34'sd30679;
    localparam logic signed [CONV_W-1:0] GB_Q16 = 34'sd12276;

    localparam logic [NUM_W-1:0]    NUM_SCALE = 38'd6553600;
    localparam logic [MASK_W-1:0]   MASK_ONE  = 17'h10000;
    localparam logic [MASK_W:0]     MASK_TWO  = 18'h20000;

    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_ZERO = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;

endpackage

[src/ypbpr_to_rgb_lowlight_blend_top.sv]
// ----------------------------------------------------------------------------
// ypbpr_to_rgb_lowlight_blend_top
// Stages from input item to result item: capture, mask setup,
//   17 restoring divider stages, mask, multiply, sum, round and clamp.
// Throughput: one item per cycle; each stage holds only while the stage after
//   it is full and blocked, so bubbles close up under output stall.
// Reset: rst_n clears the stage valid bits and loads the registers with
//   lowlight off, color mode, median level 256 and adjust 0.
// ----------------------------------------------------------------------------
module ypbpr_to_rgb_lowlight_blend_top #(
    parameter int SAMPLE_FRAC_BITS = yrlb_pkg::SAMPLE_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // luma_value, blue_diff, red_diff, orig_red, orig_green, orig_blue
    input  logic [yrlb_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_red, out_green, out_blue
    output logic [yrlb_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [yrlb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [yrlb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int F      = SAMPLE_FRAC_BITS;
    localparam int QW     = yrlb_pkg::QUOT_W;
    localparam int DenW   = yrlb_pkg::T_W - 1 + F;
    localparam int CmpW   = DenW + QW + 1;
    localparam int ProdW  = yrlb_pkg::CONV_W + yrlb_pkg::MASK_W + 1;
    localparam int SumW   = ((ProdW > F + 42) ? ProdW : F + 42) + 1;
    localparam int ByteLo = F + 32;
    localparam int ByteHi = F + 39;
    localparam int NST    = QW + 6;
    localparam logic signed [SumW-1:0] RndHalf = SumW'(1) << (F + 31);

    typedef struct packed {
        logic signed [yrlb_pkg::CONV_W-1:0] conv_r;
        logic signed [yrlb_pkg::CONV_W-1:0] conv_g;
        logic signed [yrlb_pkg::CONV_W-1:0] conv_b;
        logic [7:0]                         orig_r;
        logic [7:0]                         orig_g;
        logic [7:0]                         orig_b;
        logic                               gray;
        logic                               last;
        logic [1:0]                         mode;
        logic [yrlb_pkg::NUM_W-1:0]         rem;
        logic [QW-1:0]                      quot;
    } div_t;

    typedef struct packed {
        logic signed [yrlb_pkg::CONV_W-1:0] conv_r;
        logic signed [yrlb_pkg::CONV_W-1:0] conv_g;
        logic signed [yrlb_pkg::CONV_W-1:0] conv_b;
        logic [7:0]                         orig_r;
        logic [7:0]                         orig_g;
        logic [7:0]                         orig_b;
        logic                               gray;
        logic                               last;
        logic [yrlb_pkg::MASK_W-1:0]        mask;
    } mask_t;

    typedef struct packed {
        logic signed [ProdW-1:0]            prod_r;
        logic signed [ProdW-1:0]            prod_g;
        logic signed [ProdW-1:0]            prod_b;
        logic [yrlb_pkg::OPART_W-1:0]       opart_r;
        logic [yrlb_pkg::OPART_W-1:0]       opart_g;
        logic [yrlb_pkg::OPART_W-1:0]       opart_b;
        logic [7:0]                         orig_g;
        logic [7:0]                         orig_b;
        logic                               gray;
        logic                               last;
    } prod_t;

    typedef struct packed {
        logic signed [SumW-1:0]             sum_r;
        logic signed [SumW-1:0]             sum_g;
        logic signed [SumW-1:0]             sum_b;
        logic [7:0]                         orig_g;
        logic [7:0]                         orig_b;
        logic                               gray;
        logic                               last;
    } sum_t;

    typedef struct packed {
        logic [7:0] out_b;
        logic [7:0] out_g;
        logic [7:0] out_r;
        logic       last;
    } out_t;

    function automatic logic signed [SumW-1:0] blend_sum(
        input logic signed [ProdW-1:0]      prod,
        input logic [yrlb_pkg::OPART_W-1:0] opart
    );
        logic signed [SumW-1:0] op_ext;
        op_ext = $signed({{(SumW - yrlb_pkg::OPART_W){1'b0}}, opart});
        return SumW'(prod) + (op_ext <<< (F + 16));
    endfunction

    function automatic logic [7:0] round_clamp(input logic signed [SumW-1:0] sum);
        logic signed [SumW-1:0] rnd;
        logic [7:0]             res;
        rnd = sum + RndHalf;
        if (sum < 0)
            res = 8'd0;
        else if (|rnd[SumW-1:ByteHi+1])
            res = 8'hff;
        else
            res = rnd[ByteHi:ByteLo];
        return res;
    endfunction

    logic                          lowlight_enable_reg;
    logic                          color_mode_reg;
    logic [8:0]                    median_level_reg;
    logic signed [7:0]             threshold_adjust_reg;

    logic [11:0]                   med;
    logic signed [13:0]            fac;
    logic signed [yrlb_pkg::T_CALC_W-1:0] t_wide;
    logic [DenW-1:0]               den_reg, den_next;
    logic                          tpos_reg, tpos_next;

    logic [NST-1:0]                vld_reg;
    logic [NST-1:0]                vin;
    logic [NST:0]                  rdy;

    div_t                          s0_reg, s0_next;
    div_t                          dv_reg [0:QW];
    div_t                          dv_next [0:QW];
    mask_t                         mk_reg, mk_next;
    prod_t                         pd_reg, pd_next;
    sum_t                          sm_reg, sm_next;
    out_t                          ot_reg, ot_next;

    logic signed [15:0]                  y_in, pb_in, pr_in;
    logic signed [yrlb_pkg::CONV_W-1:0]  yq, pb_x, pr_x;
    logic signed [yrlb_pkg::CONV_W-1:0]  cr, cg, cb;
    logic [yrlb_pkg::MASK_W-1:0]         inv_mask;

    // ------------------------------------------------------------------------
    // Configuration registers and threshold divisor
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowlight_enable_reg  <= 1'b0;
            color_mode_reg       <= 1'b1;
            median_level_reg     <= 9'd256;
            threshold_adjust_reg <= 8'sd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                yrlb_pkg::REG_LOWLIGHT: lowlight_enable_reg  <= cfg_data[0];
                yrlb_pkg::REG_COLOR:    color_mode_reg       <= cfg_data[0];
                yrlb_pkg::REG_MEDIAN:   median_level_reg     <= cfg_data;
                yrlb_pkg::REG_ADJUST:   threshold_adjust_reg <= $signed(cfg_data[7:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        med = {median_level_reg, 3'b000};
        if (threshold_adjust_reg > 0)
            fac = 14'sd255 - $signed({2'b00, med});
        else
            fac = $signed({2'b00, med});
        t_wide = $signed({10'b0, med}) * 22'sd100 + fac * threshold_adjust_reg;
        tpos_next = (t_wide > 0);
        den_next  = tpos_next ? {t_wide[yrlb_pkg::T_W-2:0], {F{1'b0}}} : '0;
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        tpos_reg <= tpos_next;
    end

    // ------------------------------------------------------------------------
    // Stage handshake
    // ------------------------------------------------------------------------
    assign rdy[NST] = m_tready;
    assign vin      = {vld_reg[NST-2:0], s_tvalid};

    for (genvar g = 0; g < NST; g++)
    begin : g_rdy
        assign rdy[g] = !vld_reg[g] || rdy[g+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vin[i];
            end
        end
    end

    assign s_tready = rdy[0];

    // ------------------------------------------------------------------------
    // Capture: color conversion and mask dividend
    // ------------------------------------------------------------------------
    always_comb
    begin
        y_in  = $signed(s_tdata[15:0]);
        pb_in = $signed(s_tdata[31:16]);
        pr_in = $signed(s_tdata[47:32]);
        yq    = yrlb_pkg::CONV_W'($signed({y_in, 16'h0000}));
        pb_x  = yrlb_pkg::CONV_W'(pb_in);
        pr_x  = yrlb_pkg::CONV_W'(pr_in);
        cr    = yq + pr_x * yrlb_pkg::CR_Q16;
        cg    = yq - pr_x * yrlb_pkg::GR_Q16 - pb_x * yrlb_pkg::GB_Q16;
        cb    = yq + pb_x * yrlb_pkg::CB_Q16;

        s0_next        = '0;
        s0_next.conv_r = color_mode_reg ? cr : yq;
        s0_next.conv_g = cg;
        s0_next.conv_b = cb;
        s0_next.orig_r = s_tdata[55:48];
        s0_next.orig_g = s_tdata[63:56];
        s0_next.orig_b = s_tdata[71:64];
        s0_next.gray   = !color_mode_reg;
        s0_next.last   = s_tlast;
        s0_next.mode   = yrlb_pkg::MODE_FULL;
        s0_next.rem    = (y_in > 0) ?
                         yrlb_pkg::NUM_W'(y_in[14:0]) * yrlb_pkg::NUM_SCALE : '0;
        s0_next.quot   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            s0_reg <= s0_next;
    end

    // ------------------------------------------------------------------------
    // Mask setup: pick mode, drop quotients that saturate the mask to zero
    // ------------------------------------------------------------------------
    always_comb
    begin
        dv_next[0] = s0_reg;
        if (!lowlight_enable_reg)
            dv_next[0].mode = yrlb_pkg::MODE_FULL;
        else if (!tpos_reg)
            dv_next[0].mode = yrlb_pkg::MODE_ZERO;
        else if (s0_reg.rem == '0)
            dv_next[0].mode = yrlb_pkg::MODE_FULL;
        else if (CmpW'(s0_reg.rem) >= (CmpW'(den_reg) << QW))
            dv_next[0].mode = yrlb_pkg::MODE_ZERO;
        else
            dv_next[0].mode = yrlb_pkg::MODE_DIV;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            dv_reg[0] <= dv_next[0];
    end

    // ------------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, MSB first
    // ------------------------------------------------------------------------
    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        localparam int Bit = QW - k;
        logic [CmpW-1:0] trial;

        always_comb
        begin
            trial      = CmpW'(den_reg) << Bit;
            dv_next[k] = dv_reg[k-1];
            if (CmpW'(dv_reg[k-1].rem) >= trial)
            begin
                dv_next[k].rem       = yrlb_pkg::NUM_W'(CmpW'(dv_reg[k-1].rem) - trial);
                dv_next[k].quot[Bit] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k+1])
                dv_reg[k] <= dv_next[k];
        end
    end

    // ------------------------------------------------------------------------
    // Mask = min(2 - q, 1) in Q16
    // ------------------------------------------------------------------------
    always_comb
    begin
        mk_next.conv_r = dv_reg[QW].conv_r;
        mk_next.conv_g = dv_reg[QW].conv_g;
        mk_next.conv_b = dv_reg[QW].conv_b;
        mk_next.orig_r = dv_reg[QW].orig_r;
        mk_next.orig_g = dv_reg[QW].orig_g;
        mk_next.orig_b = dv_reg[QW].orig_b;
        mk_next.gray   = dv_reg[QW].gray;
        mk_next.last   = dv_reg[QW].last;
        unique case (dv_reg[QW].mode)
            yrlb_pkg::MODE_FULL: mk_next.mask = yrlb_pkg::MASK_ONE;
            yrlb_pkg::MODE_DIV:
            begin
                if (dv_reg[QW].quot <= yrlb_pkg::MASK_ONE)
                    mk_next.mask = yrlb_pkg::MASK_ONE;
                else
                    mk_next.mask = yrlb_pkg::MASK_W'(yrlb_pkg::MASK_TWO
                                   - (yrlb_pkg::MASK_W + 1)'(dv_reg[QW].quot));
            end
            default:             mk_next.mask = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[QW+2])
            mk_reg <= mk_next;
    end

    // ------------------------------------------------------------------------
    // Blend products
    // ------------------------------------------------------------------------
    always_comb
    begin
        inv_mask        = yrlb_pkg::MASK_ONE - mk_reg.mask;
        pd_next.prod_r  = mk_reg.conv_r * $signed({1'b0, mk_reg.mask});
        pd_next.prod_g  = mk_reg.conv_g * $signed({1'b0, mk_reg.mask});
        pd_next.prod_b  = mk_reg.conv_b * $signed({1'b0, mk_reg.mask});
        pd_next.opart_r = yrlb_pkg::OPART_W'(mk_reg.orig_r) * yrlb_pkg::OPART_W'(inv_mask);
        pd_next.opart_g = yrlb_pkg::OPART_W'(mk_reg.orig_g) * yrlb_pkg::OPART_W'(inv_mask);
        pd_next.opart_b = yrlb_pkg::OPART_W'(mk_reg.orig_b) * yrlb_pkg::OPART_W'(inv_mask);
        pd_next.orig_g  = mk_reg.orig_g;
        pd_next.orig_b  = mk_reg.orig_b;
        pd_next.gray    = mk_reg.gray;
        pd_next.last    = mk_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[QW+3])
            pd_reg <= pd_next;
    end

    always_comb
    begin
        sm_next.sum_r  = blend_sum(pd_reg.prod_r, pd_reg.opart_r);
        sm_next.sum_g  = blend_sum(pd_reg.prod_g, pd_reg.opart_g);
        sm_next.sum_b  = blend_sum(pd_reg.prod_b, pd_reg.opart_b);
        sm_next.orig_g = pd_reg.orig_g;
        sm_next.orig_b = pd_reg.orig_b;
        sm_next.gray   = pd_reg.gray;
        sm_next.last   = pd_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[QW+4])
            sm_reg <= sm_next;
    end

    // ------------------------------------------------------------------------
    // Round, clamp, pass green and blue through in gray mode
    // ------------------------------------------------------------------------
    always_comb
    begin
        ot_next.out_r = round_clamp(sm_reg.sum_r);
        ot_next.out_g = sm_reg.gray ? sm_reg.orig_g : round_clamp(sm_reg.sum_g);
        ot_next.out_b = sm_reg.gray ? sm_reg.orig_b : round_clamp(sm_reg.sum_b);
        ot_next.last  = sm_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[QW+5])
            ot_reg <= ot_next;
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {ot_reg.out_b, ot_reg.out_g, ot_reg.out_r};
    assign m_tlast  = ot_reg.last;

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side is free");

    a_div_only_when_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && dv_reg[0].mode == yrlb_pkg::MODE_DIV) |->
        (lowlight_enable_reg && tpos_reg))
        else $error("division selected without a positive threshold");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[QW+1] && dv_reg[QW].mode == yrlb_pkg::MODE_DIV) |->
        (CmpW'(dv_reg[QW].rem) < CmpW'(den_reg)))
        else $error("divider remainder not below divisor");

    a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW+2] |-> (mk_reg.mask <= yrlb_pkg::MASK_ONE))
        else $error("mask above one");
`endif

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// YPbPr to RGB low-light blend testbench
// Streams pixels through the converter under several register settings and
// handshake patterns, predicts each output pixel in fixed point, and compares
// every result byte and the frame flag against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC         = yrlb_pkg::SAMPLE_FRAC_BITS_DEF;
    localparam longint UNITY        = 65536;
    localparam longint K_RV         = 103206;
    localparam longint K_BU         = 121609;
    localparam longint K_GV         = 30679;
    localparam longint K_GU         = 12276;
    localparam int     PHASE_PIXELS = 140;
    localparam int     HOLD_PIXELS  = 120;
    localparam int     HOLD_LEN     = 300;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 200000;

    typedef struct {
        logic signed [yrlb_pkg::SAMPLE_W-1:0] luma;
        logic signed [yrlb_pkg::SAMPLE_W-1:0] pb;
        logic signed [yrlb_pkg::SAMPLE_W-1:0] pr;
        logic [yrlb_pkg::BYTE_W-1:0]          orig_r;
        logic [yrlb_pkg::BYTE_W-1:0]          orig_g;
        logic [yrlb_pkg::BYTE_W-1:0]          orig_b;
        logic                                 last;
    } pixel_t;

    typedef struct {
        logic [yrlb_pkg::BYTE_W-1:0] red;
        logic [yrlb_pkg::BYTE_W-1:0] green;
        logic [yrlb_pkg::BYTE_W-1:0] blue;
        logic                        last;
    } rgb_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [yrlb_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [yrlb_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            cfg_we;
    logic [yrlb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [yrlb_pkg::CFG_DATA_W-1:0] cfg_data;

    logic       lowlight_on;
    logic       color_on;
    logic [8:0] median_lvl;
    logic [7:0] adjust_pct;

    rgb_t rgb_expected[$];
    int   send_idle     = 0;
    int   recv_stall    = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_cycles   = 0;
    int   mismatches    = 0;
    int   pixels_sent   = 0;
    int   results_seen  = 0;
    int   settings_used = 0;
    int   cycle_count   = 0;

    ypbpr_to_rgb_lowlight_blend_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // luma_value, blue_diff, red_diff, orig_red, orig_green, orig_blue
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_red, out_green, out_blue
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint threshold_x100();
        longint med;
        longint adj;
        med = longint'(median_lvl) * 8;
        adj = longint'($signed(adjust_pct));
        if (adj > 0)
            return med * 100 + (255 - med) * adj;
        return med * (100 + adj);
    endfunction

    function automatic longint mask_q16(input longint y);
        longint t;
        longint q;
        if (!lowlight_on)
            return UNITY;
        t = threshold_x100();
        if (t <= 0)
            return 0;
        if (y <= 0)
            return UNITY;
        q = (y * 64'd6553600) / (t <<< FRAC);
        if (q >= 2 * UNITY)
            return 0;
        q = 2 * UNITY - q;
        return (q > UNITY) ? UNITY : q;
    endfunction

    function automatic logic [7:0] blend_byte(input longint conv, input longint mask,
                                              input logic [7:0] orig);
        longint total;
        total = conv * mask
              + longint'(orig) * (longint'(1) <<< (FRAC + 16)) * (UNITY - mask);
        if (total < 0)
            return 8'd0;
        total = (total + (longint'(1) <<< (FRAC + 31))) >>> (FRAC + 32);
        return (total > 255) ? 8'd255 : 8'(total);
    endfunction

    function automatic rgb_t predict_rgb(input pixel_t p);
        rgb_t   res;
        longint y;
        longint pb;
        longint pr;
        longint m;
        longint yq;
        y  = p.luma;
        pb = p.pb;
        pr = p.pr;
        m  = mask_q16(y);
        yq = y * UNITY;
        if (color_on)
        begin
            res.red   = blend_byte(yq + K_RV * pr, m, p.orig_r);
            res.green = blend_byte(yq - K_GV * pr - K_GU * pb, m, p.orig_g);
            res.blue  = blend_byte(yq + K_BU * pb, m, p.orig_b);
        end
        else
        begin
            res.red   = blend_byte(yq, m, p.orig_r);
            res.green = p.orig_g;
            res.blue  = p.orig_b;
        end
        res.last = p.last;
        return res;
    endfunction

    function automatic pixel_t make_pixel(input int luma, input int pb, input int pr,
                                          input int r, input int g, input int b,
                                          input bit last);
        pixel_t p;
        p.luma   = 16'(luma);
        p.pb     = 16'(pb);
        p.pr     = 16'(pr);
        p.orig_r = 8'(r);
        p.orig_g = 8'(g);
        p.orig_b = 8'(b);
        p.last   = last;
        return p;
    endfunction

    // Keep most luma values around the mask ramp (T..2T) of the current setting.
    function automatic pixel_t random_pixel();
        pixel_t p;
        longint t;
        int     span;
        t = threshold_x100();
        if (!lowlight_on || t <= 0)
            span = 16383;
        else
        begin
            t = t * 8 / 5;
            span = (t > 32767) ? 32767 : ((t < 64) ? 64 : int'(t));
        end
        if ($urandom_range(9) < 4)
        begin
            p.luma = 16'($urandom);
            p.pb   = 16'($urandom);
            p.pr   = 16'($urandom);
        end
        else
        begin
            p.luma = 16'($urandom_range(span));
            p.pb   = 16'($urandom_range(16383) - 8192);
            p.pr   = 16'($urandom_range(16383) - 8192);
        end
        p.orig_r = 8'($urandom);
        p.orig_g = 8'($urandom);
        p.orig_b = 8'($urandom);
        p.last   = ($urandom_range(15) == 0);
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.orig_b, p.orig_g, p.orig_r, p.pr, p.pb, p.luma};
        s_tlast  <= p.last;
        do
            @(posedge clk);
        while (!s_tready);
        rgb_expected.push_back(predict_rgb(p));
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (rgb_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [yrlb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [yrlb_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            yrlb_pkg::REG_LOWLIGHT: lowlight_on = value[0];
            yrlb_pkg::REG_COLOR:    color_on    = value[0];
            yrlb_pkg::REG_MEDIAN:   median_lvl  = value[8:0];
            yrlb_pkg::REG_ADJUST:   adjust_pct  = value[7:0];
            default:      ;
        endcase
    endtask

    task automatic configure(input bit ll, input bit color, input int med, input int adj);
        wait_idle();
        write_reg(yrlb_pkg::REG_LOWLIGHT, 9'(ll));
        write_reg(yrlb_pkg::REG_COLOR, 9'(color));
        write_reg(yrlb_pkg::REG_MEDIAN, 9'(med));
        write_reg(yrlb_pkg::REG_ADJUST, {1'b0, 8'(adj)});
        settings_used++;
    endtask

    task automatic test_conversion_extremes();
        configure(0, 1, 256, 0);
        send_pixel(make_pixel(32767, 32767, 32767, 0, 0, 0, 0));
        send_pixel(make_pixel(-32768, -32768, -32768, 255, 255, 255, 0));
        send_pixel(make_pixel(0, 0, 0, 255, 0, 255, 1));
        send_pixel(make_pixel(16320, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(8192, 2048, -2048, 17, 34, 51, 1));
    endtask

    // Threshold of exactly 255: probe below zero, on the ramp and past 2T.
    task automatic test_lowlight_mask();
        configure(1, 1, 1, 100);
        send_pixel(make_pixel(0, 1000, -1000, 200, 100, 50, 0));
        send_pixel(make_pixel(-64, 500, 500, 0, 255, 0, 0));
        send_pixel(make_pixel(16320, -3000, 3000, 0, 0, 0, 0));
        send_pixel(make_pixel(24448, 1200, -800, 255, 128, 7, 0));
        send_pixel(make_pixel(32767, 32767, -32768, 9, 99, 199, 1));
    endtask

    task automatic test_gray_mode();
        configure(1, 0, 1, 100);
        send_pixel(make_pixel(12000, 32767, -32768, 10, 20, 30, 0));
        send_pixel(make_pixel(-32768, -1, 1, 255, 1, 2, 1));
        configure(0, 0, 256, 0);
        send_pixel(make_pixel(32767, 0, 0, 0, 255, 255, 0));
    endtask

    task automatic test_zero_threshold();
        configure(1, 1, 256, -100);
        send_pixel(make_pixel(5000, 4000, -4000, 12, 34, 56, 0));
        send_pixel(make_pixel(-5000, -4000, 4000, 250, 5, 128, 1));
        configure(1, 1, 0, 0);
        send_pixel(make_pixel(20000, 100, 100, 77, 88, 99, 0));
    endtask

    task automatic test_random_settings();
        bit ll_tab[8]    = '{0, 1, 1, 1, 1, 0, 1, 1};
        bit color_tab[8] = '{1, 1, 0, 1, 1, 0, 0, 1};
        int med_tab[8]   = '{256, 32, 1, 256, 100, 200, 0, 511};
        int adj_tab[8]   = '{0, 0, 100, -100, 50, -50, 127, -1};
        int idle_tab[4]  = '{0, 57, 0, 12};
        int stall_tab[4] = '{0, 0, 57, 12};
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph < 8)
                configure(ll_tab[ph], color_tab[ph], med_tab[ph], adj_tab[ph]);
            else
                configure(1, ph[0], $urandom_range(256, 1), $urandom_range(200) - 100);
            send_idle  = idle_tab[ph % 4];
            recv_stall = stall_tab[ph % 4];
            repeat (PHASE_PIXELS * 8 / 10) send_pixel(random_pixel());
        end
        send_idle  = 0;
        recv_stall = 0;
    endtask

    // Hold the output long enough for the pipeline to fill and back up the input.
    task automatic test_output_hold();
        configure(1, 1, 64, 20);
        send_idle  = 0;
        recv_stall = 0;
        @(posedge clk);
        hold_requests++;
        @(negedge clk);
        repeat (HOLD_PIXELS) send_pixel(random_pixel());
        recv_stall = 57;
        repeat (HOLD_PIXELS / 2) send_pixel(random_pixel());
        recv_stall = 0;
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_cycles = HOLD_LEN;
        end
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin : result_check
        rgb_t got;
        rgb_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.red   = m_tdata[7:0];
            got.green = m_tdata[15:8];
            got.blue  = m_tdata[23:16];
            got.last  = m_tlast;
            if (rgb_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel r=%0d g=%0d b=%0d last=%0b",
                             $realtime, got.red, got.green, got.blue, got.last);
            end
            else
            begin
                want = rgb_expected.pop_front();
                if (got.red !== want.red || got.green !== want.green
                    || got.blue !== want.blue || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: pixel %0d expected r=%0d g=%0d b=%0d last=%0b,",
                                 $realtime, results_seen, want.red, want.green,
                                 want.blue, want.last,
                                 " got r=%0d g=%0d b=%0d last=%0b",
                                 got.red, got.green, got.blue, got.last);
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, rgb_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        lowlight_on = 1'b0;
        color_on    = 1'b1;
        median_lvl  = 9'd256;
        adjust_pct  = 8'd0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_conversion_extremes();
        test_lowlight_mask();
        test_gray_mode();
        test_zero_threshold();
        test_random_settings();
        test_output_hold();
        wait_idle();

        $display("%0d pixels over %0d register settings: gray and color, low-light on and off,",
                 pixels_sent, settings_used);
        $display("zero and out-of-range thresholds, input gaps, output stalls and a %0d-cycle hold",
                 HOLD_LEN);
        if (mismatches == 0 && rgb_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
